>>> hw/rtl/mre_pkg.sv
// Package for the mouse report encoder: report encoding codes, button code flags,
// token and event types, and the sizing of the binary to decimal converter.
// It depends on nothing. All other files of the block import it.
package mre_pkg;

  localparam int BIN_W          = 16;
  localparam int BCD_DIGITS     = 5;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int DABBLE_STAGES  = 4;
  localparam int DABBLE_STEPS   = BIN_W / DABBLE_STAGES;

  localparam int TOK_BYTES      = 5;
  localparam int NUM_TOK        = 7;

  typedef logic [BCD_W+BIN_W-1:0] dabble_t;

  typedef enum logic [1:0] {
    PROTO_LEGACY = 2'd0,
    PROTO_UTF8   = 2'd1,
    PROTO_SGR    = 2'd2,
    PROTO_URXVT  = 2'd3
  } proto_t;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_DRAG    = 2'd2,
    MODE_MOVE    = 2'd3
  } mode_t;

  localparam logic [15:0] LEGACY_LIMIT = 16'd223;
  localparam logic [7:0]  CODE_OFFSET  = 8'd32;
  localparam logic [7:0]  CODE_RELEASE = 8'd3;
  localparam logic [7:0]  FLAG_MOTION  = 8'h20;
  localparam logic [7:0]  FLAG_SCROLL  = 8'h40;
  localparam logic [7:0]  FLAG_EXTRA   = 8'h80;

  localparam logic [7:0]  CH_M_UPPER   = 8'h4D;
  localparam logic [7:0]  CH_M_LOWER   = 8'h6D;
  localparam logic [7:0]  CH_LESS      = 8'h3C;
  localparam logic [7:0]  CH_SEMI      = 8'h3B;
  localparam logic [3:0]  CH_DIGIT_HI  = 4'h3;

  // A token is a run of one to TOK_BYTES bytes, sent from bytes[0] upward.
  typedef struct packed {
    logic [TOK_BYTES-1:0][7:0] bytes;
    logic [2:0]                len;
  } token_t;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  cb;
    mode_t       mode;
    logic        empty;
  } evt_t;

endpackage

>>> hw/rtl/mouse_report_encoder.sv
// Top level of the mouse report encoder: event register, button code logic,
// decimal conversion pipeline (mre_bcd), report assembly and byte serializer.
// Uses mre_pkg.
//
// Channel | Direction | Contents
// in_*    | slave     | one mouse event per transaction
// out_*   | master     | one report byte per transaction, tlast on the final byte
// cfg_*   | write only | report encoding register
//
// An event passes an input register and four decimal conversion stages and is
// then loaded into the serializer. It sends one byte per cycle while out_tready
// is high. A report is 1 to 17 bytes long; the next report can follow directly
// after the last byte of the previous one. A stall on the output holds the
// serializer and, once the last conversion stage holds an event, the pipeline.
// Reset is synchronous and clears the valid bits and the encoding register.
module mouse_report_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // col [15:0], row [31:16], button [35:32], modifier_keys [38:36]
  input  logic [39:0] in_tdata,
  // mode [1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte [7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // empty_res [0]
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);
  import mre_pkg::*;

  proto_t      proto_r;

  logic        in_vld_r;
  logic [15:0] in_col_r;
  logic [15:0] in_row_r;
  logic [3:0]  in_btn_r;
  logic [1:0]  in_mode_r;
  logic [2:0]  in_mods_r;

  logic [DABBLE_STAGES-1:0] pipe_vld_r;
  evt_t                     pipe_evt_r [DABBLE_STAGES];

  evt_t        evt0;
  logic [7:0]  cbdec0;
  logic        adv;
  logic        load_ok;

  logic [BCD_W-1:0] cb_bcd;
  logic [BCD_W-1:0] col_bcd;
  logic [BCD_W-1:0] row_bcd;

  token_t      rec_tok [NUM_TOK];
  logic [2:0]  rec_ntok;
  logic        rec_empty;
  evt_t        evt4;

  logic        ser_busy_r, ser_busy_nxt;
  token_t      ser_tok_r   [NUM_TOK];
  token_t      ser_tok_nxt [NUM_TOK];
  logic [2:0]  ser_ntok_r, ser_ntok_nxt;
  logic        ser_empty_r, ser_empty_nxt;

  function automatic token_t lit_token(logic [7:0] b);
    token_t t;
    t          = '0;
    t.bytes[0] = b;
    t.len      = 3'd1;
    return t;
  endfunction

  function automatic token_t dec_token(logic [BCD_W-1:0] bcd);
    token_t     t;
    logic [2:0] nd;
    logic [2:0] idx;
    t = '0;
    if (bcd[19:16] != 4'd0) begin
      nd = 3'd5;
    end else if (bcd[15:12] != 4'd0) begin
      nd = 3'd4;
    end else if (bcd[11:8] != 4'd0) begin
      nd = 3'd3;
    end else if (bcd[7:4] != 4'd0) begin
      nd = 3'd2;
    end else begin
      nd = 3'd1;
    end
    for (int j = 0; j < TOK_BYTES; j++) begin
      idx = 3'(nd - 3'(j) - 3'd1);
      if (3'(j) < nd) begin
        t.bytes[j] = {CH_DIGIT_HI, bcd[4*idx +: 4]};
      end
    end
    t.len = nd;
    return t;
  endfunction

  function automatic token_t utf8_token(logic [16:0] cp);
    token_t t;
    t = '0;
    if (cp < 17'h80) begin
      t.bytes[0] = cp[7:0];
      t.len      = 3'd1;
    end else if (cp < 17'h800) begin
      t.bytes[0] = {3'b110, cp[10:6]};
      t.bytes[1] = {2'b10, cp[5:0]};
      t.len      = 3'd2;
    end else if (cp < 17'h10000) begin
      t.bytes[0] = {4'b1110, cp[15:12]};
      t.bytes[1] = {2'b10, cp[11:6]};
      t.bytes[2] = {2'b10, cp[5:0]};
      t.len      = 3'd3;
    end else begin
      t.bytes[0] = 8'hF0;
      t.bytes[1] = {3'b100, cp[16:12]};
      t.bytes[2] = {2'b10, cp[11:6]};
      t.bytes[3] = {2'b10, cp[5:0]};
      t.len      = 3'd4;
    end
    return t;
  endfunction

  assign load_ok   = !ser_busy_r || (out_tready && out_tlast);
  assign adv       = !pipe_vld_r[DABBLE_STAGES-1] || load_ok;
  assign in_tready = adv;

  always_comb begin
    logic [7:0] cb;
    logic       bad;
    mode_t      md;
    md  = mode_t'(in_mode_r);
    cb  = '0;
    bad = 1'b0;
    priority if (md == MODE_MOVE) begin
      cb = CODE_RELEASE;
    end else if (in_btn_r[3:2] == 2'b10) begin
      cb = FLAG_EXTRA | {6'd0, in_btn_r[1:0]};
    end else if (in_btn_r[3:2] == 2'b01) begin
      cb = FLAG_SCROLL | {6'd0, in_btn_r[1:0]};
    end else if (in_btn_r[3:2] == 2'b00 && in_btn_r[1:0] != 2'b00) begin
      cb = {6'd0, 2'(in_btn_r[1:0] - 2'd1)};
    end else begin
      bad = 1'b1;
    end
    if (md == MODE_DRAG || md == MODE_MOVE) begin
      cb = cb | FLAG_MOTION;
    end else if (md == MODE_RELEASE && proto_r != PROTO_SGR) begin
      cb = CODE_RELEASE;
    end
    cb = cb | {3'd0, in_mods_r, 2'd0};

    evt0.col   = in_col_r;
    evt0.row   = in_row_r;
    evt0.cb    = cb;
    evt0.mode  = md;
    evt0.empty = bad || (proto_r == PROTO_LEGACY &&
                         (in_col_r > LEGACY_LIMIT || in_row_r > LEGACY_LIMIT));
    cbdec0     = (proto_r == PROTO_URXVT) ? 8'(cb + CODE_OFFSET) : cb;
  end

  mre_bcd u_bcd_cb (
    .clk   (clk),
    .en    (adv),
    .bin_i ({8'd0, cbdec0}),
    .bcd_o (cb_bcd)
  );

  mre_bcd u_bcd_col (
    .clk   (clk),
    .en    (adv),
    .bin_i (in_col_r),
    .bcd_o (col_bcd)
  );

  mre_bcd u_bcd_row (
    .clk   (clk),
    .en    (adv),
    .bin_i (in_row_r),
    .bcd_o (row_bcd)
  );

  assign evt4 = pipe_evt_r[DABBLE_STAGES-1];

  always_comb begin
    for (int i = 0; i < NUM_TOK; i++) begin
      rec_tok[i] = '0;
    end
    rec_ntok  = 3'd1;
    rec_empty = 1'b0;
    if (evt4.empty) begin
      rec_tok[0] = lit_token(8'd0);
      rec_empty  = 1'b1;
    end else begin
      unique case (proto_r)
        PROTO_LEGACY: begin
          rec_tok[0] = lit_token(CH_M_UPPER);
          rec_tok[1] = lit_token(8'(evt4.cb + CODE_OFFSET));
          rec_tok[2] = lit_token(8'(evt4.col[7:0] + CODE_OFFSET));
          rec_tok[3] = lit_token(8'(evt4.row[7:0] + CODE_OFFSET));
          rec_ntok   = 3'd4;
        end
        PROTO_UTF8: begin
          rec_tok[0] = lit_token(CH_M_UPPER);
          rec_tok[1] = lit_token(8'(evt4.cb + CODE_OFFSET));
          rec_tok[2] = utf8_token(17'({1'b0, evt4.col} + 17'(CODE_OFFSET)));
          rec_tok[3] = utf8_token(17'({1'b0, evt4.row} + 17'(CODE_OFFSET)));
          rec_ntok   = 3'd4;
        end
        PROTO_SGR: begin
          rec_tok[0] = lit_token(CH_LESS);
          rec_tok[1] = dec_token(cb_bcd);
          rec_tok[2] = lit_token(CH_SEMI);
          rec_tok[3] = dec_token(col_bcd);
          rec_tok[4] = lit_token(CH_SEMI);
          rec_tok[5] = dec_token(row_bcd);
          rec_tok[6] = lit_token((evt4.mode == MODE_RELEASE) ? CH_M_LOWER : CH_M_UPPER);
          rec_ntok   = 3'd7;
        end
        PROTO_URXVT: begin
          rec_tok[0] = dec_token(cb_bcd);
          rec_tok[1] = lit_token(CH_SEMI);
          rec_tok[2] = dec_token(col_bcd);
          rec_tok[3] = lit_token(CH_SEMI);
          rec_tok[4] = dec_token(row_bcd);
          rec_tok[5] = lit_token(CH_M_UPPER);
          rec_ntok   = 3'd6;
        end
        default: begin
          rec_tok[0] = lit_token(8'd0);
        end
      endcase
    end
  end

  always_comb begin
    ser_busy_nxt  = ser_busy_r;
    ser_tok_nxt   = ser_tok_r;
    ser_ntok_nxt  = ser_ntok_r;
    ser_empty_nxt = ser_empty_r;
    if (load_ok) begin
      ser_busy_nxt  = pipe_vld_r[DABBLE_STAGES-1];
      ser_tok_nxt   = rec_tok;
      ser_ntok_nxt  = rec_ntok;
      ser_empty_nxt = rec_empty;
    end else if (out_tready) begin
      if (ser_tok_r[0].len == 3'd1) begin
        for (int i = 0; i < NUM_TOK - 1; i++) begin
          ser_tok_nxt[i] = ser_tok_r[i+1];
        end
        ser_tok_nxt[NUM_TOK-1] = '0;
        ser_ntok_nxt = 3'(ser_ntok_r - 3'd1);
      end else begin
        ser_tok_nxt[0].bytes = ser_tok_r[0].bytes >> 8;
        ser_tok_nxt[0].len   = 3'(ser_tok_r[0].len - 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r    <= PROTO_LEGACY;
      in_vld_r   <= 1'b0;
      pipe_vld_r <= '0;
      ser_busy_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        proto_r <= proto_t'(cfg_wdata);
      end
      if (adv) begin
        in_vld_r   <= in_tvalid;
        pipe_vld_r <= {pipe_vld_r[DABBLE_STAGES-2:0], in_vld_r};
      end
      ser_busy_r <= ser_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_col_r      <= in_tdata[15:0];
      in_row_r      <= in_tdata[31:16];
      in_btn_r      <= in_tdata[35:32];
      in_mode_r     <= in_tuser;
      in_mods_r     <= in_tdata[38:36];
      pipe_evt_r[0] <= evt0;
      for (int k = 1; k < DABBLE_STAGES; k++) begin
        pipe_evt_r[k] <= pipe_evt_r[k-1];
      end
    end
    ser_tok_r   <= ser_tok_nxt;
    ser_ntok_r  <= ser_ntok_nxt;
    ser_empty_r <= ser_empty_nxt;
  end

  assign out_tvalid = ser_busy_r;
  assign out_tdata  = ser_tok_r[0].bytes[0];
  assign out_tlast  = (ser_ntok_r == 3'd1) && (ser_tok_r[0].len == 3'd1);
  assign out_tuser  = ser_empty_r;

endmodule

>>> hw/rtl/mre_bcd.sv
// Pipelined binary to decimal converter of the mouse report encoder.
// Shift-and-add-three over DABBLE_STAGES registered stages; uses mre_pkg.
module mre_bcd (
  input  logic                     clk,
  input  logic                     en,
  input  logic [mre_pkg::BIN_W-1:0] bin_i,
  output logic [mre_pkg::BCD_W-1:0] bcd_o
);
  import mre_pkg::*;

  dabble_t st_r   [DABBLE_STAGES];
  dabble_t st_nxt [DABBLE_STAGES];

  function automatic dabble_t dabble(dabble_t v);
    dabble_t x;
    x = v;
    for (int s = 0; s < DABBLE_STEPS; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (x[BIN_W+4*d +: 4] >= 4'd5) begin
          x[BIN_W+4*d +: 4] = x[BIN_W+4*d +: 4] + 4'd3;
        end
      end
      x = x << 1;
    end
    return x;
  endfunction

  always_comb begin
    st_nxt[0] = dabble({{BCD_W{1'b0}}, bin_i});
    for (int k = 1; k < DABBLE_STAGES; k++) begin
      st_nxt[k] = dabble(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign bcd_o = st_r[DABBLE_STAGES-1][BIN_W +: BCD_W];

endmodule
